// File: hdl/jtag_scan_master_top_defines.svh
// Assertion macros shared by the JTAG scan master top level.
// Depends on nothing; every macro samples on aclk and is disabled while aresetn is low.
`ifndef JTAG_SCAN_MASTER_TOP_DEFINES_SVH
`define JTAG_SCAN_MASTER_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define JSM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("jtag scan master: implication check failed");

// The condition must never be observed.
`define JSM_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("jtag scan master: forbidden condition observed");

`endif

// File: hdl/jsm_pkg.sv
// Package for the JTAG scan master: action codes, TMS sequences and queue types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package jsm_pkg;

    // Default scan length limit and fixed port widths
    localparam int MAX_SCAN_BITS_DEF = 64;
    localparam int ACTION_W          = 2;
    localparam int SHIFT_W           = 64;
    localparam int LENGTH_W          = 7;
    localparam int CAPTURE_W         = 64;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_TAP_RESET = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_IR_SCAN   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DR_SCAN   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_TICK      = 2'd3;

    // Header and trailer sequence widths
    localparam int HDR_PAT_W = 23;
    localparam int HDR_CNT_W = 5;
    localparam int TRL_PAT_W = 4;
    localparam int TRL_CNT_W = 3;

    // TMS sequences, sent least significant bit first
    localparam logic [HDR_PAT_W-1:0] RESET_TMS       = 23'h5fffff;
    localparam logic [HDR_CNT_W-1:0] RESET_LEN       = 5'd23;
    localparam logic [HDR_PAT_W-1:0] IR_TMS          = 23'd1;
    localparam logic [HDR_CNT_W-1:0] IR_LEN          = 5'd3;
    localparam logic [HDR_PAT_W-1:0] DR_TMS          = 23'd0;
    localparam logic [HDR_CNT_W-1:0] DR_LEN          = 5'd2;
    localparam logic [TRL_PAT_W-1:0] TRAIL_IDLE_TMS  = 4'd11;
    localparam logic [TRL_CNT_W-1:0] TRAIL_IDLE_LEN  = 3'd4;
    localparam logic [TRL_PAT_W-1:0] TRAIL_PAUSE_TMS = 4'd7;
    localparam logic [TRL_CNT_W-1:0] TRAIL_PAUSE_LEN = 3'd3;

    // Depth of the queue between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // Decoded transaction as it travels through the queue
    typedef struct packed {
        logic                 is_tick;
        logic                 tdo;
        logic [HDR_PAT_W-1:0] hdr_pattern;
        logic [HDR_CNT_W-1:0] hdr_left;
        logic [TRL_PAT_W-1:0] trl_pattern;
        logic [TRL_CNT_W-1:0] trl_left;
    } jsm_cmd_t;

endpackage

// File: hdl/jsm_front.sv
// Front end of the JTAG scan master: classifies each incoming transaction and
// decodes it into header, trailer and shift settings. Depends on jsm_pkg.
`timescale 1ns / 1ps

module jsm_front
    import jsm_pkg::*;
#(
    parameter int MAX_SCAN_BITS = MAX_SCAN_BITS_DEF
) (
    input  logic [ACTION_W-1:0]                      s_action,
    input  logic [SHIFT_W-1:0]                       s_shift_in,
    input  logic [LENGTH_W-1:0]                      s_length,
    input  logic                                     s_end_in_idle,
    input  logic                                     s_tdo,
    output jsm_cmd_t                                 cmd,
    output logic [MAX_SCAN_BITS-1:0]                 shift_data,
    output logic [$clog2(MAX_SCAN_BITS + 1)-1:0]     scan_len
);

    localparam int CNT_W = $clog2(MAX_SCAN_BITS + 1);

    logic len_over;

    // Lengths beyond the supported maximum are clamped to it.
    assign len_over   = (s_length > LENGTH_W'(MAX_SCAN_BITS));
    assign shift_data = s_shift_in[MAX_SCAN_BITS-1:0];

    // Decode the action into the sequences the back end will run.
    always_comb begin
        cmd.is_tick     = (s_action == ACT_TICK);
        cmd.tdo         = s_tdo;
        cmd.hdr_pattern = DR_TMS;
        cmd.hdr_left    = DR_LEN;
        cmd.trl_pattern = s_end_in_idle ? TRAIL_IDLE_TMS : TRAIL_PAUSE_TMS;
        cmd.trl_left    = s_end_in_idle ? TRAIL_IDLE_LEN : TRAIL_PAUSE_LEN;
        scan_len        = len_over ? CNT_W'(MAX_SCAN_BITS) : s_length[CNT_W-1:0];
        case (s_action)
            ACT_TAP_RESET: begin
                cmd.hdr_pattern = RESET_TMS;
                cmd.hdr_left    = RESET_LEN;
                cmd.trl_pattern = '0;
                cmd.trl_left    = '0;
                scan_len        = '0;
            end
            ACT_IR_SCAN: begin
                cmd.hdr_pattern = IR_TMS;
                cmd.hdr_left    = IR_LEN;
            end
            ACT_DR_SCAN: begin
                cmd.hdr_pattern = DR_TMS;
                cmd.hdr_left    = DR_LEN;
            end
            default: begin
                cmd.hdr_pattern = DR_TMS;
                cmd.hdr_left    = DR_LEN;
            end
        endcase
    end

endmodule

// File: hdl/jsm_queue.sv
// Short first-in first-out queue that decouples the front end from the back end.
// Depends on jsm_pkg for its depth.
`timescale 1ns / 1ps

module jsm_queue
    import jsm_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output logic [DATA_W-1:0] rd_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count update, wrapping at the queue depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage is written on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hdl/jsm_back.sv
// Back end of the JTAG scan master: the TAP sequencer that runs header, shift and
// trailer one TCK cycle per tick, with a registered result stage. Depends on jsm_pkg.
`timescale 1ns / 1ps

module jsm_back
    import jsm_pkg::*;
#(
    parameter int MAX_SCAN_BITS = MAX_SCAN_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  jsm_cmd_t                             cmd,
    input  logic [MAX_SCAN_BITS-1:0]             shift_data,
    input  logic [$clog2(MAX_SCAN_BITS + 1)-1:0] scan_len,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_clock_cycle,
    output logic                                 m_tms,
    output logic                                 m_tdi,
    output logic                                 m_busy_res,
    output logic                                 m_done_res,
    output logic [CAPTURE_W-1:0]                 m_captured,
    output logic                                 m_rejected
);

    localparam int CNT_W = $clog2(MAX_SCAN_BITS + 1);
    localparam int IDX_W = (MAX_SCAN_BITS > 1) ? $clog2(MAX_SCAN_BITS) : 1;

    // Sequencer phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_SHIFT   = 2'd2;
    localparam logic [1:0] PH_TRAILER = 2'd3;

    logic [1:0]               phase_reg, phase_next;
    logic [HDR_PAT_W-1:0]     hdr_pat_reg, hdr_pat_next;
    logic [HDR_CNT_W-1:0]     hdr_left_reg, hdr_left_next;
    logic [TRL_PAT_W-1:0]     trl_pat_reg, trl_pat_next;
    logic [TRL_CNT_W-1:0]     trl_left_reg, trl_left_next;
    logic [MAX_SCAN_BITS-1:0] out_shift_reg, out_shift_next;
    logic [MAX_SCAN_BITS-1:0] in_capture_reg, in_capture_next;
    logic [CNT_W-1:0]         bit_index_reg, bit_index_next;
    logic [CNT_W-1:0]         scan_len_reg, scan_len_next;
    logic                     tdi_level_reg, tdi_level_next;

    logic                     m_valid_reg;
    logic                     clock_cycle_reg, clock_cycle_next;
    logic                     tms_reg, tms_next;
    logic                     busy_reg;
    logic                     done_reg, done_next;
    logic [CAPTURE_W-1:0]     captured_reg;
    logic                     rejected_reg, rejected_next;

    logic                     step;
    logic [CNT_W:0]           bit_inc;

    // A queued transaction is taken whenever the result stage is free or draining.
    assign q_ready = !m_valid_reg || m_ready;
    assign step    = q_valid && q_ready;
    assign bit_inc = {1'b0, bit_index_reg} + 1'b1;

    // Sequencer next state and result for the transaction at the queue head.
    always_comb begin
        phase_next       = phase_reg;
        hdr_pat_next     = hdr_pat_reg;
        hdr_left_next    = hdr_left_reg;
        trl_pat_next     = trl_pat_reg;
        trl_left_next    = trl_left_reg;
        out_shift_next   = out_shift_reg;
        in_capture_next  = in_capture_reg;
        bit_index_next   = bit_index_reg;
        scan_len_next    = scan_len_reg;
        tdi_level_next   = tdi_level_reg;
        clock_cycle_next = 1'b0;
        tms_next         = 1'b0;
        done_next        = 1'b0;
        rejected_next    = 1'b0;
        if (!cmd.is_tick) begin
            // Commands load the sequencer only when it is idle.
            if (phase_reg != PH_IDLE) begin
                rejected_next = 1'b1;
            end else begin
                out_shift_next  = shift_data;
                in_capture_next = '0;
                bit_index_next  = '0;
                hdr_pat_next    = cmd.hdr_pattern;
                hdr_left_next   = cmd.hdr_left;
                trl_pat_next    = cmd.trl_pattern;
                trl_left_next   = cmd.trl_left;
                scan_len_next   = scan_len;
                phase_next      = PH_HEADER;
            end
        end else begin
            case (phase_reg)
                PH_HEADER: begin
                    clock_cycle_next = 1'b1;
                    tms_next         = hdr_pat_reg[0];
                    hdr_pat_next     = hdr_pat_reg >> 1;
                    if (hdr_left_reg != '0) begin
                        hdr_left_next = hdr_left_reg - 1'b1;
                    end
                    if (hdr_left_next == '0) begin
                        if (scan_len_reg != '0) begin
                            phase_next = PH_SHIFT;
                        end else if (trl_left_reg != '0) begin
                            phase_next = PH_TRAILER;
                        end else begin
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                end
                PH_SHIFT: begin
                    clock_cycle_next = 1'b1;
                    tdi_level_next   = out_shift_reg[0];
                    out_shift_next   = out_shift_reg >> 1;
                    in_capture_next[bit_index_reg[IDX_W-1:0]] = cmd.tdo;
                    bit_index_next   = bit_inc[CNT_W-1:0];
                    if (bit_inc >= {1'b0, scan_len_reg}) begin
                        if (trl_left_reg != '0) begin
                            phase_next = PH_TRAILER;
                        end else begin
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                end
                PH_TRAILER: begin
                    clock_cycle_next = 1'b1;
                    tms_next         = trl_pat_reg[0];
                    trl_pat_next     = trl_pat_reg >> 1;
                    if (trl_left_reg != '0) begin
                        trl_left_next = trl_left_reg - 1'b1;
                    end
                    if (trl_left_next == '0) begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                default: begin
                    // A tick while idle leaves everything as it is.
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Sequencer control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            hdr_pat_reg   <= '0;
            hdr_left_reg  <= '0;
            trl_pat_reg   <= '0;
            trl_left_reg  <= '0;
            bit_index_reg <= '0;
            scan_len_reg  <= '0;
            tdi_level_reg <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            hdr_pat_reg   <= hdr_pat_next;
            hdr_left_reg  <= hdr_left_next;
            trl_pat_reg   <= trl_pat_next;
            trl_left_reg  <= trl_left_next;
            bit_index_reg <= bit_index_next;
            scan_len_reg  <= scan_len_next;
            tdi_level_reg <= tdi_level_next;
        end
    end

    // Shift data and captured TDO bits.
    always_ff @(posedge aclk) begin
        if (step) begin
            out_shift_reg  <= out_shift_next;
            in_capture_reg <= in_capture_next;
        end
    end

    // Result stage valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result stage payload.
    always_ff @(posedge aclk) begin
        if (step) begin
            clock_cycle_reg <= clock_cycle_next;
            tms_reg         <= tms_next;
            busy_reg        <= (phase_next != PH_IDLE);
            done_reg        <= done_next;
            captured_reg    <= done_next ? CAPTURE_W'(in_capture_next) : '0;
            rejected_reg    <= rejected_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_clock_cycle = clock_cycle_reg;
    assign m_tms         = tms_reg;
    assign m_tdi         = tdi_level_reg;
    assign m_busy_res    = busy_reg;
    assign m_done_res    = done_reg;
    assign m_captured    = captured_reg;
    assign m_rejected    = rejected_reg;

endmodule

// File: hdl/jtag_scan_master_top.sv
// JTAG scan master top level: front decoder, decoupling queue and TAP sequencer.
// Depends on jsm_pkg, jsm_front, jsm_queue, jsm_back and the assertion header.
`timescale 1ns / 1ps
`include "jtag_scan_master_top_defines.svh"

// The block takes one transaction per clock while its queue has room and the
// receiver takes results, and returns exactly one result for each. A command
// (TAP reset, instruction scan or data scan) loads the sequencer and makes no TCK
// pulse; every following tick transaction until the command completes makes one
// TCK cycle, reporting the TMS and TDI levels driven and, in the shift, capturing
// the TDO level given with it. A command that arrives while another is still
// running is dropped and flagged as rejected. A transaction waits in the
// decoupling queue and its result is then registered in the result stage before
// it is presented; the sustained rate is one transaction per clock, set by the
// sequencer, which updates its state once per transaction. Scans are limited to
// MAX_SCAN_BITS bits and longer lengths are clamped; the TDO bits of a scan are
// reported on the result that completes the command.
module jtag_scan_master_top
    import jsm_pkg::*;
#(
    parameter int MAX_SCAN_BITS = MAX_SCAN_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ACTION_W-1:0]  s_action,
    input  logic [SHIFT_W-1:0]   s_shift_in,
    input  logic [LENGTH_W-1:0]  s_length,
    input  logic                 s_end_in_idle,
    input  logic                 s_tdo,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_clock_cycle,
    output logic                 m_tms,
    output logic                 m_tdi,
    output logic                 m_busy_res,
    output logic                 m_done_res,
    output logic [CAPTURE_W-1:0] m_captured,
    output logic                 m_rejected
);

    localparam int CNT_W  = $clog2(MAX_SCAN_BITS + 1);
    localparam int CMD_W  = $bits(jsm_cmd_t);
    localparam int DATA_W = CMD_W + MAX_SCAN_BITS + CNT_W;

    jsm_cmd_t                 front_cmd;
    logic [MAX_SCAN_BITS-1:0] front_shift;
    logic [CNT_W-1:0]         front_len;
    logic [DATA_W-1:0]        wr_data;
    logic [DATA_W-1:0]        rd_data;
    logic                     q_valid;
    logic                     q_ready;
    jsm_cmd_t                 back_cmd;
    logic [MAX_SCAN_BITS-1:0] back_shift;
    logic [CNT_W-1:0]         back_len;

    // Classify and decode each incoming transaction.
    jsm_front #(
        .MAX_SCAN_BITS (MAX_SCAN_BITS)
    ) u_front (
        .s_action      (s_action),
        .s_shift_in    (s_shift_in),
        .s_length      (s_length),
        .s_end_in_idle (s_end_in_idle),
        .s_tdo         (s_tdo),
        .cmd           (front_cmd),
        .shift_data    (front_shift),
        .scan_len      (front_len)
    );

    assign wr_data = {front_cmd, front_shift, front_len};

    // Queue between decoder and sequencer.
    jsm_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (wr_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (rd_data)
    );

    assign {back_cmd, back_shift, back_len} = rd_data;

    // TAP sequencer and result register.
    jsm_back #(
        .MAX_SCAN_BITS (MAX_SCAN_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .cmd           (back_cmd),
        .shift_data    (back_shift),
        .scan_len      (back_len),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_clock_cycle (m_clock_cycle),
        .m_tms         (m_tms),
        .m_tdi         (m_tdi),
        .m_busy_res    (m_busy_res),
        .m_done_res    (m_done_res),
        .m_captured    (m_captured),
        .m_rejected    (m_rejected)
    );

    // A finished command leaves the sequencer idle, and only a clocked tick finishes one.
    `JSM_ASSERT_IMPLY(a_done_not_busy, m_valid && m_done_res, !m_busy_res && m_clock_cycle)
    // A rejected command means one was running, and it makes no TCK pulse.
    `JSM_ASSERT_IMPLY(a_reject_busy, m_valid && m_rejected, m_busy_res && !m_clock_cycle)
    // Capture data is only reported with the completion of a command.
    `JSM_ASSERT_IMPLY(a_capture_with_done, m_valid && !m_done_res, m_captured == '0)
    // A rejected command can never complete anything.
    `JSM_ASSERT_NEVER(a_reject_done, m_valid && m_rejected && m_done_res)

endmodule

// File: test/jsm_scan_checker.sv
// Scoreboard for the JTAG scan master: watches both channels, predicts every result and compares.
// Depends on jsm_pkg for the action codes, TMS sequences and port widths.
`timescale 1ns / 1ps

module jsm_scan_checker
    import jsm_pkg::*;
#(
    parameter int MAX_SCAN_BITS = MAX_SCAN_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [ACTION_W-1:0]  s_action,
    input  logic [SHIFT_W-1:0]   s_shift_in,
    input  logic [LENGTH_W-1:0]  s_length,
    input  logic                 s_end_in_idle,
    input  logic                 s_tdo,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_clock_cycle,
    input  logic                 m_tms,
    input  logic                 m_tdi,
    input  logic                 m_busy_res,
    input  logic                 m_done_res,
    input  logic [CAPTURE_W-1:0] m_captured,
    input  logic                 m_rejected,
    output int                   error_count,
    output int                   outstanding
);

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_HEADER,
        SEQ_SHIFT,
        SEQ_TRAILER
    } seq_phase_t;

    typedef struct packed {
        logic                 clock_cycle;
        logic                 tms;
        logic                 tdi;
        logic                 busy;
        logic                 done;
        logic [CAPTURE_W-1:0] captured;
        logic                 rejected;
    } tap_result_t;

    // Shadow copy of the TAP sequencer state.
    seq_phase_t           seq_phase;
    logic [HDR_PAT_W-1:0] hdr_pattern;
    logic [HDR_CNT_W-1:0] hdr_left;
    logic [TRL_PAT_W-1:0] trl_pattern;
    logic [TRL_CNT_W-1:0] trl_left;
    logic [SHIFT_W-1:0]   tdi_shift;
    logic [CAPTURE_W-1:0] tdo_capture;
    logic [LENGTH_W-1:0]  shift_count;
    logic [LENGTH_W-1:0]  shift_total;
    logic                 tdi_level;

    tap_result_t expected_results[$];

    initial begin
        error_count = 0;
        outstanding = 0;
    end

    // Applies one accepted transaction to the shadow sequencer and returns its result.
    function automatic tap_result_t advance_tap_sequencer(
        input logic [ACTION_W-1:0] act,
        input logic [SHIFT_W-1:0]  bits,
        input logic [LENGTH_W-1:0] len,
        input logic                end_idle,
        input logic                tdo
    );
        tap_result_t r;
        r = '0;
        if (act != ACT_TICK) begin
            if (seq_phase != SEQ_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                tdi_shift   = bits;
                tdo_capture = '0;
                shift_count = '0;
                if (act == ACT_TAP_RESET) begin
                    hdr_pattern = RESET_TMS;
                    hdr_left    = RESET_LEN;
                    shift_total = '0;
                    trl_pattern = '0;
                    trl_left    = '0;
                end else begin
                    hdr_pattern = (act == ACT_IR_SCAN) ? IR_TMS : DR_TMS;
                    hdr_left    = (act == ACT_IR_SCAN) ? IR_LEN : DR_LEN;
                    shift_total = (len > MAX_SCAN_BITS) ? LENGTH_W'(MAX_SCAN_BITS) : len;
                    trl_pattern = end_idle ? TRAIL_IDLE_TMS : TRAIL_PAUSE_TMS;
                    trl_left    = end_idle ? TRAIL_IDLE_LEN : TRAIL_PAUSE_LEN;
                end
                seq_phase = SEQ_HEADER;
            end
        end else begin
            case (seq_phase)
                SEQ_HEADER: begin
                    r.clock_cycle = 1'b1;
                    r.tms         = hdr_pattern[0];
                    hdr_pattern   = hdr_pattern >> 1;
                    if (hdr_left != 0) begin
                        hdr_left = hdr_left - 1'b1;
                    end
                    // An empty shift goes straight on to the trailer, or ends the command.
                    if (hdr_left == 0) begin
                        if (shift_total != 0) begin
                            seq_phase = SEQ_SHIFT;
                        end else if (trl_left != 0) begin
                            seq_phase = SEQ_TRAILER;
                        end else begin
                            seq_phase = SEQ_IDLE;
                            r.done    = 1'b1;
                        end
                    end
                end
                SEQ_SHIFT: begin
                    r.clock_cycle = 1'b1;
                    tdi_level     = tdi_shift[0];
                    tdi_shift     = tdi_shift >> 1;
                    tdo_capture   = tdo_capture | (CAPTURE_W'(tdo) << shift_count[5:0]);
                    shift_count   = shift_count + 1'b1;
                    if (shift_count >= shift_total) begin
                        if (trl_left != 0) begin
                            seq_phase = SEQ_TRAILER;
                        end else begin
                            seq_phase = SEQ_IDLE;
                            r.done    = 1'b1;
                        end
                    end
                end
                SEQ_TRAILER: begin
                    r.clock_cycle = 1'b1;
                    r.tms         = trl_pattern[0];
                    trl_pattern   = trl_pattern >> 1;
                    if (trl_left != 0) begin
                        trl_left = trl_left - 1'b1;
                    end
                    if (trl_left == 0) begin
                        seq_phase = SEQ_IDLE;
                        r.done    = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        r.tdi  = tdi_level;
        r.busy = (seq_phase != SEQ_IDLE);
        if (r.done) begin
            r.captured = tdo_capture;
        end
        return r;
    endfunction

    task automatic compare_field(
        input string               field,
        input logic [CAPTURE_W-1:0] want,
        input logic [CAPTURE_W-1:0] got
    );
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            error_count = error_count + 1;
        end
    endtask

    // Results are matched first, so a transaction accepted in the same cycle queues behind them.
    always @(posedge aclk) begin : watch
        tap_result_t want;
        if (!aresetn) begin
            seq_phase   = SEQ_IDLE;
            hdr_pattern = '0;
            hdr_left    = '0;
            trl_pattern = '0;
            trl_left    = '0;
            tdi_shift   = '0;
            tdo_capture = '0;
            shift_count = '0;
            shift_total = '0;
            tdi_level   = 1'b0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transaction with nothing expected, captured %h",
                             $time, m_captured);
                    error_count = error_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("clock_cycle", CAPTURE_W'(want.clock_cycle),
                                  CAPTURE_W'(m_clock_cycle));
                    compare_field("tms", CAPTURE_W'(want.tms), CAPTURE_W'(m_tms));
                    compare_field("tdi", CAPTURE_W'(want.tdi), CAPTURE_W'(m_tdi));
                    compare_field("busy_res", CAPTURE_W'(want.busy), CAPTURE_W'(m_busy_res));
                    compare_field("done_res", CAPTURE_W'(want.done), CAPTURE_W'(m_done_res));
                    compare_field("captured", want.captured, m_captured);
                    compare_field("rejected", CAPTURE_W'(want.rejected),
                                  CAPTURE_W'(m_rejected));
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(advance_tap_sequencer(
                    s_action, s_shift_in, s_length, s_end_in_idle, s_tdo));
            end
        end
        outstanding = expected_results.size();
    end

endmodule

// File: test/testbench.sv
// Top of the JTAG scan master testbench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on jsm_pkg, jtag_scan_master_top and the jsm_scan_checker scoreboard.
`timescale 1ns / 1ps

module testbench;
    import jsm_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [ACTION_W-1:0]  s_action;
    logic [SHIFT_W-1:0]   s_shift_in;
    logic [LENGTH_W-1:0]  s_length;
    logic                 s_end_in_idle;
    logic                 s_tdo;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_clock_cycle;
    logic                 m_tms;
    logic                 m_tdi;
    logic                 m_busy_res;
    logic                 m_done_res;
    logic [CAPTURE_W-1:0] m_captured;
    logic                 m_rejected;

    int error_count;
    int outstanding;
    int sent_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    jtag_scan_master_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_shift_in    (s_shift_in),
        .s_length      (s_length),
        .s_end_in_idle (s_end_in_idle),
        .s_tdo         (s_tdo),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_clock_cycle (m_clock_cycle),
        .m_tms         (m_tms),
        .m_tdi         (m_tdi),
        .m_busy_res    (m_busy_res),
        .m_done_res    (m_done_res),
        .m_captured    (m_captured),
        .m_rejected    (m_rejected)
    );

    jsm_scan_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_shift_in    (s_shift_in),
        .s_length      (s_length),
        .s_end_in_idle (s_end_in_idle),
        .s_tdo         (s_tdo),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_clock_cycle (m_clock_cycle),
        .m_tms         (m_tms),
        .m_tdi         (m_tdi),
        .m_busy_res    (m_busy_res),
        .m_done_res    (m_done_res),
        .m_captured    (m_captured),
        .m_rejected    (m_rejected),
        .error_count   (error_count),
        .outstanding   (outstanding)
    );

    // 8 ns clock.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // The receiver stalls at random according to the current phase.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Presents one transaction at a falling edge and holds it until accepted.
    task automatic send_transaction(
        input logic [ACTION_W-1:0] act,
        input logic [SHIFT_W-1:0]  bits,
        input logic [LENGTH_W-1:0] len,
        input logic                end_idle,
        input logic                tdo
    );
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_shift_in    <= bits;
        s_length      <= len;
        s_end_in_idle <= end_idle;
        s_tdo         <= tdo;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        sent_count++;
    endtask

    // A tick carries random noise on the fields that it does not use.
    task automatic send_tick();
        send_transaction(ACT_TICK, {$urandom, $urandom}, LENGTH_W'($urandom_range(127)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    function automatic logic [ACTION_W-1:0] pick_command();
        int pick;
        pick = $urandom_range(2);
        if (pick == 0) begin
            return ACT_TAP_RESET;
        end else if (pick == 1) begin
            return ACT_IR_SCAN;
        end
        return ACT_DR_SCAN;
    endfunction

    // Holds the sender back until every expected result has been seen.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge aclk);
    endtask

    // One command followed by the ticks that complete it; now and then a stray
    // command mid-way, a sequence cut short, or extra ticks once idle.
    task automatic run_command_sequence();
        logic [ACTION_W-1:0] act;
        logic [LENGTH_W-1:0] len;
        logic [SHIFT_W-1:0]  bits;
        logic                end_idle;
        int                  pick;
        int                  ticks;
        act  = pick_command();
        pick = $urandom_range(99);
        if (pick < 5) begin
            len = '0;
        end else if (pick < 10) begin
            len = LENGTH_W'(MAX_SCAN_BITS_DEF);
        end else if (pick < 15) begin
            len = LENGTH_W'($urandom_range(127, MAX_SCAN_BITS_DEF + 1));
        end else if (pick < 30) begin
            len = LENGTH_W'($urandom_range(MAX_SCAN_BITS_DEF - 1, 13));
        end else begin
            len = LENGTH_W'($urandom_range(12, 1));
        end
        pick = $urandom_range(99);
        if (pick < 3) begin
            bits = '1;
        end else if (pick < 6) begin
            bits = '0;
        end else begin
            bits = {$urandom, $urandom};
        end
        end_idle = 1'($urandom_range(1));
        if (act == ACT_TAP_RESET) begin
            ticks = int'(RESET_LEN);
        end else begin
            ticks = int'((act == ACT_IR_SCAN) ? IR_LEN : DR_LEN)
                  + ((len > MAX_SCAN_BITS_DEF) ? MAX_SCAN_BITS_DEF : int'(len))
                  + int'(end_idle ? TRAIL_IDLE_LEN : TRAIL_PAUSE_LEN);
        end
        if ($urandom_range(99) < 5) begin
            ticks = $urandom_range(ticks - 1);
        end
        send_transaction(act, bits, len, end_idle, 1'($urandom_range(1)));
        repeat (ticks) begin
            if ($urandom_range(99) < 3) begin
                send_transaction(pick_command(), {$urandom, $urandom},
                                 LENGTH_W'($urandom_range(127)), 1'($urandom_range(1)),
                                 1'($urandom_range(1)));
            end
            send_tick();
        end
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(3, 1)) send_tick();
        end
    endtask

    initial begin : stimulus
        int idle_plan[4];
        int stall_plan[4];
        int target;
        idle_plan     = '{0, 87, 0, 14};
        stall_plan    = '{0, 0, 87, 14};
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_action      = ACT_TICK;
        s_shift_in    = '0;
        s_length      = '0;
        s_end_in_idle = 1'b0;
        s_tdo         = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: a tick while idle makes no clock.
        send_tick();
        // Instruction scan of length zero ending in idle, with a command rejected mid-way.
        send_transaction(ACT_IR_SCAN, '0, '0, 1'b1, 1'b0);
        send_tick();
        send_transaction(ACT_DR_SCAN, '1, LENGTH_W'(MAX_SCAN_BITS_DEF), 1'b0, 1'b1);
        repeat (6) send_tick();
        // One-bit data scan of all ones, ending in pause, with every field at its top.
        send_transaction(ACT_DR_SCAN, '1, LENGTH_W'(1), 1'b0, 1'b1);
        repeat (6) send_transaction(ACT_TICK, '1, '1, 1'b1, 1'b1);
        wait_for_drain();

        // Random phases with different idling on each side.
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct    = idle_plan[ph];
            receiver_stall_pct = stall_plan[ph];
            target             = sent_count + 500;
            while (sent_count < target) begin
                run_command_sequence();
            end
            wait_for_drain();
        end

        receiver_stall_pct = 0;
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: jtag_scan_master_top.f
+incdir+hdl
hdl/jsm_pkg.sv
hdl/jsm_front.sv
hdl/jsm_queue.sv
hdl/jsm_back.sv
hdl/jtag_scan_master_top.sv
test/jsm_scan_checker.sv
test/testbench.sv
